// ===== src/thp_pkg.sv =====
// shared types, constants and codes of the sensor compensation block
package thp_pkg;

   // queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // restoring divider, one quotient bit per stage
   localparam int DIV_W = 64;

   // compensation constants
   localparam logic signed [33:0] FINE_PRESS_OFS = 34'sd128000;
   localparam logic [31:0]        FINE_HUM_OFS   = 32'd76800;
   localparam logic [21:0]        PRESS_FULL     = 22'd1048576;
   localparam logic signed [12:0] PRESS_SCALE    = 13'sd3125;
   localparam logic [31:0]        HUM_LIMIT      = 32'd419430400;

   // register indexes
   typedef enum logic [2:0] {
      CSR_TEMP        = 3'd0,
      CSR_PRESS_LOW   = 3'd1,
      CSR_PRESS_HIGH  = 3'd2,
      CSR_PRESS_HUMID = 3'd3,
      CSR_HUMID_SHAPE = 3'd4
   } csr_index_type;

   // unpacked calibration words
   typedef struct packed {
      logic        [15:0] t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic        [15:0] p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
      logic        [7:0]  h1;
      logic signed [15:0] h2;
      logic        [7:0]  h3;
      logic signed [11:0] h4;
      logic signed [11:0] h5;
      logic signed [7:0]  h6;
   } coeff_type;

   // item handed from front to back
   typedef struct packed {
      logic signed [31:0] fine;
      logic        [15:0] temp;
      logic        [19:0] raw_pressure;
      logic        [15:0] raw_humidity;
   } item_type;

   // fields that ride along the divider
   typedef struct packed {
      logic        [15:0] temp;
      logic signed [31:0] hv;
      logic               zero;
      logic               neg;
   } side_type;

   typedef struct packed {
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
      side_type         side;
   } div_in_type;

   typedef struct packed {
      logic [DIV_W-1:0] quot;
      side_type         side;
   } div_out_type;

endpackage

// ===== src/thp_front.sv =====
// front pipeline: accepts raw readings, forms fine temperature and centidegrees
module thp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [19:0]          req_raw_temperature,
   input  logic [19:0]          req_raw_pressure,
   input  logic [15:0]          req_raw_humidity,
   input  thp_pkg::coeff_type   coeff,
   input  logic                 q_full,
   output logic                 push,
   output thp_pkg::item_type    push_item
);
   import thp_pkg::*;

   logic              en;
   logic [4:0]        vld_ff;
   logic [4:0]        vld_in;
   logic [19:0]       rp_ff [5];
   logic [15:0]       rh_ff [5];

   logic signed [31:0] d1_ff, d1_in, d2_ff, d2_in;
   logic signed [31:0] m1_ff, m1_in, m2_ff, m2_in;
   logic signed [31:0] s1_ff, s1_in, m3_ff, m3_in;
   logic signed [31:0] fine_ff, fine_in, fine5_ff;
   logic [15:0]        temp_ff, temp_in;
   logic signed [47:0] m1_full, m3_full;
   logic signed [63:0] m2_full;
   logic signed [35:0] fx, t5, tc;

   // whole pipe holds while the last item cannot enter the queue
   assign en        = !(vld_ff[4] && q_full);
   assign req_stall = !en;
   assign push      = vld_ff[4] && !q_full;
   assign push_item = '{fine: fine5_ff, temp: temp_ff,
                        raw_pressure: rp_ff[4], raw_humidity: rh_ff[4]};

   assign vld_in = {vld_ff[3:0], req_valid};

   // stage 1: offsets of the raw reading
   assign d1_in = 32'(req_raw_temperature[19:3]) - 32'({coeff.t1, 1'b0});
   assign d2_in = 32'(req_raw_temperature[19:4]) - 32'(coeff.t1);

   // stage 2: products
   assign m1_full = d1_ff * $signed(coeff.t2);
   assign m1_in   = m1_full[31:0];
   assign m2_full = d2_ff * d2_ff;
   assign m2_in   = m2_full[31:0];

   // stage 3: shift and second product
   assign s1_in   = m1_ff >>> 11;
   assign m3_full = (m2_ff >>> 12) * $signed(coeff.t3);
   assign m3_in   = m3_full[31:0];

   // stage 4: fine temperature
   assign fine_in = s1_ff + (m3_ff >>> 14);

   // stage 5: centidegrees with saturation
   assign fx = 36'(fine_ff);
   assign t5 = fx * 36'sd5 + 36'sd128;
   assign tc = t5 >>> 8;
   always_comb begin
      if (tc > 36'sd32767) begin
         temp_in = 16'h7fff;
      end else if (tc < -36'sd32768) begin
         temp_in = 16'h8000;
      end else begin
         temp_in = tc[15:0];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (en) begin
         rp_ff[0] <= req_raw_pressure;
         rh_ff[0] <= req_raw_humidity;
         for (int k = 1; k < 5; k++) begin
            rp_ff[k] <= rp_ff[k-1];
            rh_ff[k] <= rh_ff[k-1];
         end
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         s1_ff    <= s1_in;
         m3_ff    <= m3_in;
         fine_ff  <= fine_in;
         fine5_ff <= fine_ff;
         temp_ff  <= temp_in;
      end
   end

endmodule

// ===== src/thp_queue.sv =====
// short item queue between front and back
module thp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  thp_pkg::item_type  push_item,
   output logic               full,
   input  logic               pop,
   output logic               q_valid,
   output thp_pkg::item_type  q_item
);
   import thp_pkg::*;

   item_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full    = (cnt_ff == QCNT_W'(QDEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_item  = mem_ff[rd_ff];

   // pointers and fill count
   assign wr_in  = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH)) else $error("queue count above depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> !pop) else $error("pop from empty queue");

endmodule

// ===== src/thp_div.sv =====
// pipelined unsigned restoring divider with side fields
module thp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  thp_pkg::div_in_type   din,
   output logic                  out_valid,
   output thp_pkg::div_out_type  dout
);
   import thp_pkg::*;

   logic [DIV_W-1:0] rem_ff [DIV_W];
   logic [DIV_W-1:0] nq_ff  [DIV_W];
   logic [DIV_W-1:0] den_ff [DIV_W];
   side_type         side_ff [DIV_W];
   logic [DIV_W-1:0] vld_ff;

   logic [DIV_W-1:0] rem_in [DIV_W];
   logic [DIV_W-1:0] nq_in  [DIV_W];

   // one quotient bit per stage
   always_comb begin
      logic [DIV_W-1:0] r, n, d;
      logic [DIV_W:0]   t;
      for (int k = 0; k < DIV_W; k++) begin
         r = (k == 0) ? '0       : rem_ff[k > 0 ? k-1 : 0];
         n = (k == 0) ? din.num  : nq_ff[k > 0 ? k-1 : 0];
         d = (k == 0) ? din.den  : den_ff[k > 0 ? k-1 : 0];
         t = {r, n[DIV_W-1]};
         if (t >= {1'b0, d}) begin
            rem_in[k] = DIV_W'(t - {1'b0, d});
            nq_in[k]  = {n[DIV_W-2:0], 1'b1};
         end else begin
            rem_in[k] = t[DIV_W-1:0];
            nq_in[k]  = {n[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            nq_ff[k]   <= nq_in[k];
            den_ff[k]  <= (k == 0) ? din.den  : den_ff[k > 0 ? k-1 : 0];
            side_ff[k] <= (k == 0) ? din.side : side_ff[k > 0 ? k-1 : 0];
         end
      end
   end

   assign out_valid = vld_ff[DIV_W-1];
   assign dout      = '{quot: nq_ff[DIV_W-1], side: side_ff[DIV_W-1]};

endmodule

// ===== src/thp_back.sv =====
// back pipeline: pressure and humidity compensation and result register
module thp_back (
   input  logic               clock,
   input  logic               reset,
   input  thp_pkg::coeff_type coeff,
   input  logic               q_valid,
   input  thp_pkg::item_type  q_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_temperature_centi,
   output logic [31:0]        rsp_pressure_q24_8,
   output logic               rsp_pressure_valid,
   output logic [16:0]        rsp_humidity_q22_10
);
   import thp_pkg::*;

   logic       en;
   logic [7:1] bv_ff;
   logic [5:1] pv_ff;
   logic [15:0] tmp_ff [1:6];

   // stage 1
   logic signed [33:0] a0_ff, a0_in;
   logic signed [31:0] v_ff, v_in;
   logic [21:0]        p0_ff [1:4];
   logic [21:0]        p0_in;
   logic [15:0]        rh_ff;
   // stage 2
   logic signed [67:0] aa_full;
   logic signed [49:0] ap5_full, ap2_full;
   logic signed [43:0] h5v_full;
   logic signed [39:0] vh6_full;
   logic signed [40:0] vh3_full;
   logic signed [63:0] aa_ff, aa_in, ap5_ff [2:3], ap5_in, ap2_ff [2:3], ap2_in;
   logic signed [31:0] h5v_ff, h5v_in, vh6_ff, vh6_in, vh3_ff, vh3_in, xb_ff, xb_in;
   // stage 3
   logic signed [79:0] b1_full, aap3_full;
   logic signed [63:0] b1_ff, b1_in, aap3_ff, aap3_in;
   logic signed [31:0] ya, yb, x_ff, x_in, y1_ff, y1_in;
   logic signed [63:0] y1_full;
   // stage 4
   logic signed [63:0] b_ff, b_in, a2_ff, a2_in;
   logic signed [31:0] x2_ff [4:6], x2_in, y2_ff, y2_in;
   // stage 5
   logic signed [63:0] a2s;
   logic signed [80:0] a3p_full;
   logic signed [63:0] a3p_ff, a3p_in, n1_ff, n1_in;
   logic signed [47:0] y3p_full;
   logic signed [31:0] y3m_ff, y3m_in;
   // stage 6
   logic signed [76:0] num_full;
   logic signed [63:0] a3_ff, a3_in, num_ff, num_in;
   logic signed [31:0] y3_ff, y3_in;
   // stage 7
   logic signed [63:0] hv_full;
   div_in_type         din_ff, din_in;
   // divider
   logic               dv;
   div_out_type        dout;
   // post stages
   logic signed [63:0] p_ff [1:4], p_in, ps;
   logic signed [31:0] zs, zz_ff, zz_in, zq, z3_ff, z3_in, hvd;
   logic signed [63:0] zz_full;
   logic signed [41:0] zm;
   logic signed [31:0] hv_ff [1:2];
   logic               zero_ff [1:4];
   logic [15:0]        ptmp_ff [1:4];
   logic [63:0]        ll_ff, ll_in;
   logic [63:0]        hl_full;
   logic [30:0]        hl_ff, hl_in;
   logic signed [79:0] e1_full, cm_full;
   logic signed [63:0] e1_ff, e1_in, sq_ff, sq_in, e_ff [3:4], e_in, cm_ff, cm_in;
   logic [16:0]        hum_ff [3:4];
   logic [16:0]        hum_in;
   logic signed [63:0] cs, ss;
   logic [31:0]        press_in;

   // the whole back pipe holds while a result waits
   assign en  = !(pv_ff[5] && rsp_stall);
   assign pop = en && q_valid;

   // stage 1: offsets of the fine temperature
   assign a0_in = 34'(q_item.fine) - FINE_PRESS_OFS;
   assign v_in  = q_item.fine - $signed(FINE_HUM_OFS);
   assign p0_in = PRESS_FULL - 22'(q_item.raw_pressure);

   // stage 2: first products
   assign aa_full  = a0_ff * a0_ff;
   assign aa_in    = aa_full[63:0];
   assign ap5_full = a0_ff * $signed(coeff.p5);
   assign ap5_in   = 64'(ap5_full);
   assign ap2_full = a0_ff * $signed(coeff.p2);
   assign ap2_in   = 64'(ap2_full);
   assign h5v_full = $signed(coeff.h5) * v_ff;
   assign h5v_in   = h5v_full[31:0];
   assign vh6_full = v_ff * $signed(coeff.h6);
   assign vh6_in   = vh6_full[31:0];
   assign vh3_full = v_ff * $signed({1'b0, coeff.h3});
   assign vh3_in   = vh3_full[31:0];
   assign xb_in    = {2'b00, rh_ff, 14'b0} - {coeff.h4, 20'b0};

   // stage 3: second products
   assign b1_full   = aa_ff * $signed(coeff.p6);
   assign b1_in     = b1_full[63:0];
   assign aap3_full = aa_ff * $signed(coeff.p3);
   assign aap3_in   = aap3_full[63:0];
   assign x_in      = xb_ff - h5v_ff;
   assign ya        = vh6_ff >>> 10;
   assign yb        = (vh3_ff >>> 11) + 32'sd32768;
   assign y1_full   = ya * yb;
   assign y1_in     = y1_full[31:0];

   // stage 4: sums
   assign b_in  = b1_ff + (ap5_ff[3] <<< 17) + (64'($signed(coeff.p4)) <<< 35);
   assign a2_in = (aap3_ff >>> 8) + (ap2_ff[3] <<< 12);
   assign x2_in = (x_ff + 32'sd16384) >>> 15;
   assign y2_in = (y1_ff >>> 10) + 32'sd2097152;

   // stage 5: divisor product and numerator
   assign a2s      = a2_ff + 64'sh0000_8000_0000_0000;
   assign a3p_full = a2s * $signed({1'b0, coeff.p1});
   assign a3p_in   = a3p_full[63:0];
   assign n1_in    = $signed(64'(p0_ff[4]) << 31) - b_ff;
   assign y3p_full = y2_ff * $signed(coeff.h2);
   assign y3m_in   = y3p_full[31:0] + 32'sd8192;

   // stage 6: scaling
   assign a3_in    = a3p_ff >>> 33;
   assign num_full = n1_ff * PRESS_SCALE;
   assign num_in   = num_full[63:0];
   assign y3_in    = y3m_ff >>> 14;

   // stage 7: humidity product and divider operands as magnitudes
   assign hv_full = x2_ff[6] * y3_ff;
   always_comb begin
      din_in.num       = num_ff[63] ? 64'(-num_ff) : num_ff;
      din_in.den       = a3_ff[63] ? 64'(-a3_ff) : a3_ff;
      din_in.side.temp = tmp_ff[6];
      din_in.side.hv   = hv_full[31:0];
      din_in.side.zero = (a3_ff == '0);
      din_in.side.neg  = num_ff[63] ^ a3_ff[63];
   end

   thp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (bv_ff[7]),
      .din       (din_ff),
      .out_valid (dv),
      .dout      (dout)
   );

   // post 1: signed quotient, humidity square
   assign p_in    = dout.side.neg ? 64'(-$signed(dout.quot)) : $signed(dout.quot);
   assign zs      = dout.side.hv >>> 15;
   assign zz_full = zs * zs;
   assign zz_in   = zz_full[31:0];

   // post 2: square of the scaled pressure in partial products
   assign ps      = p_ff[1] >>> 13;
   assign ll_in   = ps[31:0] * ps[31:0];
   assign hl_full = ps[63:32] * ps[31:0];
   assign hl_in   = hl_full[30:0];
   assign e1_full = p_ff[1] * $signed(coeff.p8);
   assign e1_in   = e1_full[63:0];
   assign zq      = zz_ff >>> 7;
   assign zm      = zq * $signed({1'b0, coeff.h1});
   assign z3_in   = $signed(zm[31:0]) >>> 4;

   // post 3: square assembled, humidity clamp
   assign sq_in = $signed(ll_ff + {hl_ff, 33'b0});
   assign e_in  = e1_ff >>> 19;
   assign hvd   = hv_ff[2] - z3_ff;
   always_comb begin
      if (hvd[31]) begin
         hum_in = '0;
      end else if (32'(hvd) > HUM_LIMIT) begin
         hum_in = HUM_LIMIT[28:12];
      end else begin
         hum_in = hvd[28:12];
      end
   end

   // post 4: p9 term
   assign cm_full = sq_ff * $signed(coeff.p9);
   assign cm_in   = cm_full[63:0];

   // post 5: final pressure
   assign cs       = cm_ff >>> 25;
   assign ss       = ((p_ff[4] + cs + e_ff[4]) >>> 8) + (64'($signed(coeff.p7)) <<< 4);
   assign press_in = zero_ff[4] ? '0 : ss[31:0];

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= '0;
         pv_ff <= '0;
      end else if (en) begin
         bv_ff <= {bv_ff[6:1], q_valid};
         pv_ff <= {pv_ff[4:1], dv};
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (en) begin
         tmp_ff[1] <= q_item.temp;
         for (int k = 2; k < 7; k++) begin
            tmp_ff[k] <= tmp_ff[k-1];
         end
         a0_ff     <= a0_in;
         v_ff      <= v_in;
         p0_ff[1]  <= p0_in;
         for (int k = 2; k < 5; k++) begin
            p0_ff[k] <= p0_ff[k-1];
         end
         rh_ff     <= q_item.raw_humidity;
         aa_ff     <= aa_in;
         ap5_ff[2] <= ap5_in;
         ap5_ff[3] <= ap5_ff[2];
         ap2_ff[2] <= ap2_in;
         ap2_ff[3] <= ap2_ff[2];
         h5v_ff    <= h5v_in;
         vh6_ff    <= vh6_in;
         vh3_ff    <= vh3_in;
         xb_ff     <= xb_in;
         b1_ff     <= b1_in;
         aap3_ff   <= aap3_in;
         x_ff      <= x_in;
         y1_ff     <= y1_in;
         b_ff      <= b_in;
         a2_ff     <= a2_in;
         x2_ff[4]  <= x2_in;
         for (int k = 5; k < 7; k++) begin
            x2_ff[k] <= x2_ff[k-1];
         end
         y2_ff     <= y2_in;
         a3p_ff    <= a3p_in;
         n1_ff     <= n1_in;
         y3m_ff    <= y3m_in;
         a3_ff     <= a3_in;
         num_ff    <= num_in;
         y3_ff     <= y3_in;
         din_ff    <= din_in;
         // post stages
         p_ff[1]    <= p_in;
         zz_ff      <= zz_in;
         hv_ff[1]   <= dout.side.hv;
         zero_ff[1] <= dout.side.zero;
         ptmp_ff[1] <= dout.side.temp;
         hv_ff[2]   <= hv_ff[1];
         for (int k = 2; k < 5; k++) begin
            p_ff[k]    <= p_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
         for (int k = 2; k < 5; k++) begin
            ptmp_ff[k] <= ptmp_ff[k-1];
         end
         ll_ff     <= ll_in;
         hl_ff     <= hl_in;
         e1_ff     <= e1_in;
         z3_ff     <= z3_in;
         sq_ff     <= sq_in;
         e_ff[3]   <= e_in;
         e_ff[4]   <= e_ff[3];
         hum_ff[3] <= hum_in;
         hum_ff[4] <= hum_ff[3];
         cm_ff     <= cm_in;
         // result register
         rsp_temperature_centi <= ptmp_ff[4];
         rsp_pressure_q24_8    <= press_in;
         rsp_pressure_valid    <= !zero_ff[4];
         rsp_humidity_q22_10   <= hum_ff[4];
      end
   end

   assign rsp_valid = pv_ff[5];

   a_zero_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pressure_valid |-> rsp_pressure_q24_8 == '0)
      else $error("pressure not forced to zero on zero divisor");
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_q22_10 <= HUM_LIMIT[28:12])
      else $error("humidity above clamp");
   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop |=> bv_ff[1]) else $error("popped item lost in stage one");

endmodule

// ===== src/thp_sensor_compensation_unit.sv =====
// top level: calibration registers, front pipe, queue and back pipe
//
// Integer compensation of one raw temperature / pressure / humidity triple
// per item. The block takes one item per clock while req_stall is low and
// returns one result per item in order. An item passes through 82
// registers: 5 front stages, the queue storage, 7 back stages, a 64-stage
// restoring divider (one quotient bit per stage) and 5 stages of final
// pressure and humidity arithmetic ending in the result register. When the
// result is stalled the back pipe holds, the 4-entry queue fills, and then
// the front pipe holds and raises req_stall. Calibration words are written
// through the csr port (always ready); the user must write them only while
// the block is idle, which the block itself does not enforce; indexes above
// the last register are ignored.
module thp_sensor_compensation_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   input  logic [15:0]        req_raw_humidity,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_temperature_centi,
   output logic [31:0]        rsp_pressure_q24_8,
   output logic               rsp_pressure_valid,
   output logic [16:0]        rsp_humidity_q22_10,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);
   import thp_pkg::*;

   logic [47:0] temp_c_ff;
   logic [63:0] press_lo_ff;
   logic [63:0] press_hi_ff;
   logic [47:0] press_hum_ff;
   logic [31:0] hum_shape_ff;
   coeff_type   coeff;
   logic        full, push, pop, q_valid;
   item_type    push_item, q_item;

   assign csr_ready = 1'b1;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_c_ff    <= '0;
         press_lo_ff  <= '0;
         press_hi_ff  <= '0;
         press_hum_ff <= '0;
         hum_shape_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEMP:        temp_c_ff    <= csr_data[47:0];
            CSR_PRESS_LOW:   press_lo_ff  <= csr_data;
            CSR_PRESS_HIGH:  press_hi_ff  <= csr_data;
            CSR_PRESS_HUMID: press_hum_ff <= csr_data[47:0];
            CSR_HUMID_SHAPE: hum_shape_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // unpack calibration fields
   always_comb begin
      coeff.t1 = temp_c_ff[15:0];
      coeff.t2 = temp_c_ff[31:16];
      coeff.t3 = temp_c_ff[47:32];
      coeff.p1 = press_lo_ff[15:0];
      coeff.p2 = press_lo_ff[31:16];
      coeff.p3 = press_lo_ff[47:32];
      coeff.p4 = press_lo_ff[63:48];
      coeff.p5 = press_hi_ff[15:0];
      coeff.p6 = press_hi_ff[31:16];
      coeff.p7 = press_hi_ff[47:32];
      coeff.p8 = press_hi_ff[63:48];
      coeff.p9 = press_hum_ff[15:0];
      coeff.h1 = press_hum_ff[23:16];
      coeff.h2 = press_hum_ff[39:24];
      coeff.h3 = press_hum_ff[47:40];
      coeff.h4 = hum_shape_ff[11:0];
      coeff.h5 = hum_shape_ff[23:12];
      coeff.h6 = hum_shape_ff[31:24];
   end

   thp_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_raw_temperature (req_raw_temperature),
      .req_raw_pressure    (req_raw_pressure),
      .req_raw_humidity    (req_raw_humidity),
      .coeff               (coeff),
      .q_full              (full),
      .push                (push),
      .push_item           (push_item)
   );

   thp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   thp_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .coeff                 (coeff),
      .q_valid               (q_valid),
      .q_item                (q_item),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_pressure_q24_8    (rsp_pressure_q24_8),
      .rsp_pressure_valid    (rsp_pressure_valid),
      .rsp_humidity_q22_10   (rsp_humidity_q22_10)
   );

endmodule
